// ----- rtl/dtoi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types and constants for the double to integer convert unit.
// ----------------------------------------------------------------------------
package dtoi_pkg;

	typedef enum logic [2:0] {
		KIND_SAT_I32  = 3'd0,
		KIND_WRAP_I32 = 3'd1,
		KIND_WRAP_U32 = 3'd2,
		KIND_WRAP_I16 = 3'd3,
		KIND_WRAP_U16 = 3'd4
	} kind_t;

	localparam int ExpBias = 1023;
	localparam int FracW   = 52;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] value_bits;
	} in_item_t;

endpackage
`default_nettype wire

// ----- rtl/double_to_integer_convert_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each beat passes the input register and then the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; short logic feeds res_s2.
// The input stage takes a new beat whenever the result stage is empty or drains this cycle.
// Reset: arst_n clears both valid flags asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// double_to_integer_convert_unit
// Stream wrapper around the binary64 to 32-bit integer conversion logic.
// ----------------------------------------------------------------------------
module double_to_integer_convert_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,  // [63:0] value_bits
	input  wire  [2:0]  s_axis_tuser,  // [2:0] kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] result_bits
);
	import dtoi_pkg::*;

	in_item_t    item_s1;
	logic        vld_s1;
	logic        vld_s2;
	logic [31:0] res_s2;
	logic [31:0] res_c;
	logic        adv_s2;

	dtoi_core u_core (.item(item_s1), .result_bits(res_c));

	assign adv_s2        = !vld_s2 || m_axis_tready;
	assign s_axis_tready = !vld_s1 || adv_s2;
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) vld_s1 <= s_axis_tvalid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.value_bits <= s_axis_tdata;
			item_s1.kind       <= s_axis_tuser;
		end
		if (adv_s2 && vld_s1) res_s2 <= res_c;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !m_axis_tready |=> vld_s2 && $stable(res_s2))
		else $error("result lost under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_axis_tready)
		else $error("empty input stage refused a beat");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> vld_s2)
		else $error("item dropped between stages");

endmodule
`default_nettype wire

// ----- rtl/dtoi_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtoi_core
// Combinational conversion of one binary64 pattern to a 32-bit integer.
// ----------------------------------------------------------------------------
module dtoi_core (
	input  wire dtoi_pkg::in_item_t item,
	output logic [31:0]             result_bits
);
	import dtoi_pkg::*;

	logic        neg;
	logic [10:0] expo;
	logic [51:0] frac;
	logic [52:0] sig;
	logic [11:0] ex;
	logic [31:0] low;
	logic [31:0] wrapped;
	logic [31:0] sat;
	logic        is_max;
	logic        tiny;

	always_comb begin
		neg  = item.value_bits[63];
		expo = item.value_bits[62:52];
		frac = item.value_bits[51:0];
		sig  = {1'b1, frac};
		ex   = {1'b0, expo} - 12'(ExpBias);
		tiny = (expo == 11'h7FF) || (expo < 11'(ExpBias));
		low  = '0;
		// Only exponents below 84 can leave bits in the low word.
		if (!tiny) begin
			if (ex <= 12'(FracW)) begin
				low = 32'(sig >> (6'(FracW) - ex[5:0]));
			end else if (ex < 12'(FracW + 32)) begin
				low = 32'({sig, 31'b0} >> (7'd83 - ex[6:0]));
			end
		end
		wrapped = neg ? (32'd0 - low) : low;

		is_max = (expo == 11'h7FF) ? (frac == '0) : (!tiny && ex >= 12'd31);
		if (is_max) begin
			sat = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (tiny) begin
			sat = '0;
		end else begin
			sat = wrapped;
		end

		case (item.kind)
			KIND_SAT_I32:                   result_bits = sat;
			KIND_WRAP_I32, KIND_WRAP_U32:   result_bits = wrapped;
			KIND_WRAP_I16: result_bits = {{16{wrapped[15]}}, wrapped[15:0]};
			KIND_WRAP_U16: result_bits = {16'b0, wrapped[15:0]};
			default:                        result_bits = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- bench/dtoi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtoi_checker
// Watches both stream channels of the convert unit, computes the expected
// integer for every accepted operand and compares it with the result beats.
// ----------------------------------------------------------------------------
module dtoi_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [63:0] s_axis_tdata,
	input  wire  [2:0]  s_axis_tuser,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [31:0] m_axis_tdata,
	output int          errors,
	output int          pending
);
	import dtoi_pkg::*;

	logic [31:0] expected_q[$];

	// Truncated value reduced modulo 2^32, exact on the binary64 fields.
	function automatic logic [31:0] wrapped_int(input logic [63:0] v);
		logic [10:0]  e;
		logic [52:0]  sig;
		logic [31:0]  low;
		int           ex;
		e   = v[62:52];
		sig = {1'b1, v[51:0]};
		if (e == 11'h7FF || e == 11'd0) return 32'd0;
		ex = int'(e) - ExpBias;
		if (ex < 0) return 32'd0;
		if (ex <= FracW) low = 32'(sig >> (FracW - ex));
		else if (ex - FracW >= 64) low = 32'd0;
		else low = 32'({11'd0, sig} << (ex - FracW));
		return v[63] ? -low : low;
	endfunction

	function automatic logic [31:0] saturated_int(input logic [63:0] v);
		logic [10:0] e;
		logic [52:0] sig;
		logic [31:0] mag;
		int          ex;
		e   = v[62:52];
		sig = {1'b1, v[51:0]};
		if (e == 11'h7FF) begin
			if (v[51:0] != 0) return 32'd0;
			return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		if (e == 11'd0) return 32'd0;
		ex = int'(e) - ExpBias;
		if (ex < 0) return 32'd0;
		if (ex >= 31) return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		mag = 32'(sig >> (FracW - ex));
		return v[63] ? -mag : mag;
	endfunction

	function automatic logic [31:0] converted_int(input logic [2:0] k, input logic [63:0] v);
		logic [31:0] w;
		w = wrapped_int(v);
		case (k)
			KIND_SAT_I32:                 return saturated_int(v);
			KIND_WRAP_I32, KIND_WRAP_U32: return w;
			KIND_WRAP_I16:                return {{16{w[15]}}, w[15:0]};
			KIND_WRAP_U16:                return {16'd0, w[15:0]};
			default:                      return 32'd0;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	initial errors = 0;
	assign pending = expected_q.size();

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(converted_int(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0)
					report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
				else begin
					want = expected_q.pop_front();
					if (m_axis_tdata !== want)
						report_mismatch($sformatf("result_bits %h, want %h", m_axis_tdata, want));
				end
			end
		end
	end
endmodule

// ----- bench/tb_double_to_integer_convert_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_to_integer_convert_unit
// Drives operands with random gaps and back pressure into the convert unit;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_double_to_integer_convert_unit;
	import dtoi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	int          errors;
	int          pending;
	bit          hold_off;

	double_to_integer_convert_unit DUT (.*);

	dtoi_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [63:0] random_double();
		logic [63:0] v;
		int          r;
		v = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		// Bias the exponent toward the interesting range around the int32 limits.
		if (r < 6) v[62:52] = 11'(ExpBias - 2 + $urandom_range(0, 90));
		else if (r == 6) v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
		else if (r == 7) v[51:0] = $urandom_range(0, 1) ? 52'd0 : v[51:0];
		return v;
	endfunction

	task automatic send(input logic [2:0] k, input logic [63:0] v);
		int g;
		s_axis_tdata  <= v;
		s_axis_tuser  <= k;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Receiver back pressure, with one long hold-off early in the random part.
	initial begin
		int g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (60) @(negedge clk);
				hold_off = 0;
			end
			g = gap_len();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("double_to_integer_convert_unit test failed");
		$finish;
	end

	initial begin
		logic [63:0] corner[$];
		int          waited;
		hold_off      = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		corner = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h000F_FFFF_FFFF_FFFF, 64'h3FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
			64'hBFF8_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
			64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'h41DF_FFFF_FFC0_0000,
			64'h41E0_0000_0000_0000, 64'hC1E0_0000_0000_0000, 64'hC1E0_0000_0020_0000,
			64'h41F0_0000_0000_0000, 64'h41EF_FFFF_FFE0_0000, 64'h4340_0000_0000_0001,
			64'h7FEF_FFFF_FFFF_FFFF, 64'h40EF_FFE0_0000_0000, 64'h0000_0000_0000_0001};
		foreach (corner[i])
			for (int k = 0; k < 8; k++) send(3'(k), corner[i]);
		hold_off = 1;
		for (int n = 0; n < 1540; n++)
			send($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(KIND_SAT_I32, KIND_WRAP_U16)), random_double());
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 10000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("double_to_integer_convert_unit test passed");
		else
			$display("double_to_integer_convert_unit test failed");
		$finish;
	end
endmodule
